FILE: rtl/core/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg
// shared types and codes for the deadlock detector
// ----------------------------------------------------------------------------
package dd_pkg;

  localparam int ACT_W      = 2;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 4;   // process_index / resource_index / process_id
  localparam int CFG_W      = 5;   // widest configuration register
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_ALLOC = 2'd0,
    ACT_LOAD_REQ   = 2'd1,
    ACT_LOAD_AVAIL = 2'd2,
    ACT_RUN        = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMPLETED  = 2'd0,
    KIND_DEADLOCKED = 2'd1,
    KIND_SUMMARY    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PROCESSES = 2'd0,
    CFG_NUM_RESOURCES = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] num_processes;
    logic [CFG_W-1:0] num_resources;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PSEL,
    S_CRD,
    S_CEV,
    S_ARD,
    S_AEV,
    S_EMIT,
    S_DSCAN,
    S_SUM
  } dd_state_t;

endpackage

FILE: rtl/core/dd_in_if.sv
// ----------------------------------------------------------------------------
// dd_in_if
// input channel: load and run items
// ----------------------------------------------------------------------------
interface dd_in_if #(
  parameter int AMOUNT_WIDTH = 16
) ();
  logic                        valid;
  logic                        ready;
  dd_pkg::action_t             action;
  logic [dd_pkg::IDX_W-1:0]    process_index;
  logic [dd_pkg::IDX_W-1:0]    resource_index;
  logic [AMOUNT_WIDTH-1:0]     amount;

  modport source (output valid, action, process_index, resource_index, amount,
                  input ready);
  modport sink (input valid, action, process_index, resource_index, amount,
                output ready);
endinterface

FILE: rtl/core/dd_out_if.sv
// ----------------------------------------------------------------------------
// dd_out_if
// result channel: per-process reports and run summary
// ----------------------------------------------------------------------------
interface dd_out_if ();
  logic                     valid;
  logic                     ready;
  dd_pkg::kind_t            kind;
  logic [dd_pkg::IDX_W-1:0] process_id;
  logic                     any_deadlock;
  logic                     last;

  modport source (output valid, kind, process_id, any_deadlock, last,
                  input ready);
  modport sink (input valid, kind, process_id, any_deadlock, last,
                output ready);
endinterface

FILE: rtl/core/dd_ram.sv
// ----------------------------------------------------------------------------
// dd_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dd_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dd_seq.sv
// ----------------------------------------------------------------------------
// dd_seq
// run sequencer: load decode, work vector, finish marks and result register
// ----------------------------------------------------------------------------
module dd_seq #(
  parameter int MAX_PROCS     = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int AMOUNT_WIDTH  = 16,
  parameter int ADDR_W        = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dd_pkg::cfg_t            cfg,
  dd_in_if.sink                   in_ch,
  dd_out_if.source                out_ch,
  output logic                    alloc_we,
  output logic                    req_we,
  output logic [ADDR_W-1:0]       wr_addr,
  output logic [AMOUNT_WIDTH-1:0] wr_data,
  output logic [ADDR_W-1:0]       rd_addr,
  input  logic [AMOUNT_WIDTH-1:0] alloc_rdata,
  input  logic [AMOUNT_WIDTH-1:0] req_rdata
);

  localparam int PCNT_W = $clog2(MAX_PROCS + 1);
  localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int WORK_W = AMOUNT_WIDTH + $clog2(MAX_PROCS + 1);

  dd_pkg::dd_state_t state_r, state_nxt;

  logic [PCNT_W-1:0]       p_r, done_r, np_r;
  logic [RCNT_W-1:0]       r_r, nr_r;
  logic                    progress_r;
  logic                    any_dead_r;
  logic [MAX_PROCS-1:0]    fin_r;
  logic [WORK_W-1:0]       work_r  [MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] avail_r [MAX_RESOURCES];

  logic                     out_vld_r;
  dd_pkg::kind_t            out_kind_r;
  logic [dd_pkg::IDX_W-1:0] out_pid_r;
  logic                     out_dead_r;
  logic                     out_last_r;

  logic [PIDX_W-1:0] pidx;
  logic [RIDX_W-1:0] ridx;
  logic              p_end, r_end, all_done, cur_fin, req_over, out_free;
  logic              in_xfer, pi_ok, ri_ok;
  logic              emit_go;
  dd_pkg::kind_t     emit_kind;
  logic [PCNT_W-1:0] np_cfg;
  logic [RCNT_W-1:0] nr_cfg;

  assign pidx     = p_r[PIDX_W-1:0];
  assign ridx     = r_r[RIDX_W-1:0];
  assign p_end    = (p_r == np_r);
  assign r_end    = (r_r == nr_r);
  assign all_done = (done_r == np_r);
  assign cur_fin  = fin_r[pidx];
  assign req_over = (WORK_W'(req_rdata) > work_r[ridx]);
  assign out_free = !out_vld_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign pi_ok    = (int'(in_ch.process_index) < MAX_PROCS);
  assign ri_ok    = (int'(in_ch.resource_index) < MAX_RESOURCES);

  // counts above the store size clamp to it
  assign np_cfg = (int'(cfg.num_processes) > MAX_PROCS) ? PCNT_W'(MAX_PROCS)
                                                        : PCNT_W'(cfg.num_processes);
  assign nr_cfg = (int'(cfg.num_resources) > MAX_RESOURCES) ? RCNT_W'(MAX_RESOURCES)
                                                            : RCNT_W'(cfg.num_resources);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dd_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.action == dd_pkg::ACT_RUN) begin
          state_nxt = dd_pkg::S_PSEL;
        end
      end
      dd_pkg::S_PSEL: begin
        if (all_done || (p_end && !progress_r)) begin
          state_nxt = dd_pkg::S_DSCAN;
        end else if (!p_end && !cur_fin) begin
          state_nxt = dd_pkg::S_CRD;
        end
      end
      dd_pkg::S_CRD: state_nxt = r_end ? dd_pkg::S_ARD : dd_pkg::S_CEV;
      dd_pkg::S_CEV: state_nxt = req_over ? dd_pkg::S_PSEL : dd_pkg::S_CRD;
      dd_pkg::S_ARD: state_nxt = r_end ? dd_pkg::S_EMIT : dd_pkg::S_AEV;
      dd_pkg::S_AEV: state_nxt = dd_pkg::S_ARD;
      dd_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = dd_pkg::S_PSEL;
        end
      end
      dd_pkg::S_DSCAN: begin
        if (p_end) begin
          state_nxt = dd_pkg::S_SUM;
        end
      end
      dd_pkg::S_SUM: begin
        if (out_free) begin
          state_nxt = dd_pkg::S_IDLE;
        end
      end
      default: state_nxt = dd_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ch.ready = 1'b0;
    emit_go     = 1'b0;
    emit_kind   = dd_pkg::KIND_COMPLETED;
    case (state_r)
      dd_pkg::S_IDLE: in_ch.ready = 1'b1;
      dd_pkg::S_EMIT: begin
        emit_go   = out_free;
        emit_kind = dd_pkg::KIND_COMPLETED;
      end
      dd_pkg::S_DSCAN: begin
        emit_go   = out_free && !p_end && !cur_fin;
        emit_kind = dd_pkg::KIND_DEADLOCKED;
      end
      dd_pkg::S_SUM: begin
        emit_go   = out_free;
        emit_kind = dd_pkg::KIND_SUMMARY;
      end
      default: begin
        in_ch.ready = 1'b0;
        emit_go     = 1'b0;
      end
    endcase
  end

  // matrix ram ports
  assign alloc_we = in_xfer && in_ch.action == dd_pkg::ACT_LOAD_ALLOC && pi_ok && ri_ok;
  assign req_we   = in_xfer && in_ch.action == dd_pkg::ACT_LOAD_REQ && pi_ok && ri_ok;
  assign wr_addr  = ADDR_W'(int'(in_ch.process_index) * MAX_RESOURCES
                            + int'(in_ch.resource_index));
  assign wr_data  = in_ch.amount;
  assign rd_addr  = ADDR_W'(int'(pidx) * MAX_RESOURCES + int'(ridx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      dd_pkg::S_IDLE: begin
        if (in_xfer && in_ch.action == dd_pkg::ACT_LOAD_AVAIL && ri_ok) begin
          avail_r[RIDX_W'(in_ch.resource_index)] <= in_ch.amount;
        end
        if (in_xfer && in_ch.action == dd_pkg::ACT_RUN) begin
          for (int i = 0; i < MAX_RESOURCES; i++) begin
            work_r[i] <= WORK_W'(avail_r[i]);
          end
          fin_r      <= '0;
          p_r        <= '0;
          done_r     <= '0;
          progress_r <= 1'b0;
          any_dead_r <= 1'b0;
          np_r       <= np_cfg;
          nr_r       <= nr_cfg;
        end
      end
      dd_pkg::S_PSEL: begin
        if (all_done || (p_end && !progress_r)) begin
          p_r <= '0;
        end else if (p_end) begin
          // start another pass
          p_r        <= '0;
          progress_r <= 1'b0;
        end else if (cur_fin) begin
          p_r <= p_r + 1'b1;
        end else begin
          r_r <= '0;
        end
      end
      dd_pkg::S_CRD: begin
        if (r_end) begin
          r_r <= '0;
        end
      end
      dd_pkg::S_CEV: begin
        if (req_over) begin
          p_r <= p_r + 1'b1;
        end else begin
          r_r <= r_r + 1'b1;
        end
      end
      dd_pkg::S_ARD: begin
        if (r_end) begin
          fin_r[pidx] <= 1'b1;
          done_r      <= done_r + 1'b1;
          progress_r  <= 1'b1;
        end
      end
      dd_pkg::S_AEV: begin
        work_r[ridx] <= work_r[ridx] + WORK_W'(alloc_rdata);
        r_r          <= r_r + 1'b1;
      end
      dd_pkg::S_EMIT: begin
        if (out_free) begin
          p_r <= p_r + 1'b1;
        end
      end
      dd_pkg::S_DSCAN: begin
        if (!p_end) begin
          if (cur_fin) begin
            p_r <= p_r + 1'b1;
          end else if (out_free) begin
            any_dead_r <= 1'b1;
            p_r        <= p_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_kind_r <= emit_kind;
      out_pid_r  <= (emit_kind == dd_pkg::KIND_SUMMARY) ? '0
                                                        : dd_pkg::IDX_W'(p_r);
      out_dead_r <= (emit_kind == dd_pkg::KIND_SUMMARY) ? any_dead_r : 1'b0;
      out_last_r <= (emit_kind == dd_pkg::KIND_SUMMARY);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.process_id   = out_pid_r;
  assign out_ch.any_deadlock = out_dead_r;
  assign out_ch.last         = out_last_r;

endmodule

FILE: rtl/core/deadlock_detector.sv
// ----------------------------------------------------------------------------
// deadlock_detector
// resource-allocation deadlock detector over allocation and request matrices
// ----------------------------------------------------------------------------
//
//  channel   dir   transfer carries
//  --------  ----  -----------------------------------------------------------
//  in_ch     in    action, process_index, resource_index, amount
//  out_ch    out   kind, process_id, any_deadlock, last
//  cfg_*     in    write enable, register index, data (num_processes, ...)
//
//  loads are taken only while idle and give no result
//  a run walks the matrix rams one entry at a time, a read state then an
//  evaluate state per entry (one registered read port): a fit check reads
//  up to nr request entries, an allocation add reads all nr allocation
//  entries, and a report goes out for each process and for the summary
//  reset is synchronous, active low; no clearing pass (the matrices and the
//  available counts are undefined until loaded)
//  a stalled result register holds the sequencer in place; loads are taken
//  while a result waits
//
module deadlock_detector #(
  parameter int MAX_PROCS     = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int AMOUNT_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dd_pkg::CFG_W-1:0]     cfg_data,
  dd_in_if.sink                        in_ch,
  dd_out_if.source                     out_ch
);

  localparam int DEPTH  = MAX_PROCS * MAX_RESOURCES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  dd_pkg::cfg_t cfg_r;

  // matrix ram ports, driven by the sequencer
  logic                    alloc_we;
  logic                    req_we;
  logic [ADDR_W-1:0]       wr_addr;
  logic [AMOUNT_WIDTH-1:0] wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic [AMOUNT_WIDTH-1:0] alloc_rdata;
  logic [AMOUNT_WIDTH-1:0] req_rdata;

  // writes to an unknown index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_processes <= dd_pkg::CFG_COUNT_RESET;
      cfg_r.num_resources <= dd_pkg::CFG_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dd_pkg::CFG_NUM_PROCESSES: cfg_r.num_processes <= cfg_data;
        dd_pkg::CFG_NUM_RESOURCES: cfg_r.num_resources <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // allocation matrix, row-major: process * MAX_RESOURCES + resource
  dd_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (AMOUNT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (alloc_rdata)
  );

  // request matrix, same layout; read at the same address as allocation
  dd_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (AMOUNT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (req_rdata)
  );

  // sequencer: decodes loads, runs the passes, owns work and finish marks
  dd_seq #(
    .MAX_PROCS     (MAX_PROCS),
    .MAX_RESOURCES (MAX_RESOURCES),
    .AMOUNT_WIDTH  (AMOUNT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .alloc_we    (alloc_we),
    .req_we      (req_we),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .alloc_rdata (alloc_rdata),
    .req_rdata   (req_rdata)
  );

endmodule

FILE: tb/deadlock_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadlock_detector_tb
// self-checking bench for the deadlock detector: loads the allocation,
// request and available stores, runs detection and compares every report
// against an in-bench model of the safety walk
// ----------------------------------------------------------------------------
module deadlock_detector_tb;

  localparam int MAXP         = 16;
  localparam int MAXR         = 16;
  localparam int AMT_W        = 16;
  localparam int DRAIN_CYCLES = 16;          // loads give no report, keep margin
  localparam int RAND_TARGET  = 150;         // items in the random part
  localparam int LIMIT        = 3_000_000;   // watchdog, in clock cycles

  // register indexes that decode to nothing
  localparam logic [dd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [dd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    dd_pkg::kind_t            kind;
    logic [dd_pkg::IDX_W-1:0] pid;
    logic                     dead;
    logic                     last;
  } report_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [dd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dd_pkg::CFG_W-1:0]     cfg_data;

  dd_in_if #(.AMOUNT_WIDTH(AMT_W)) in_ch ();
  dd_out_if                        out_ch ();

  deadlock_detector #(
    .MAX_PROCS    (MAXP),
    .MAX_RESOURCES(MAXR),
    .AMOUNT_WIDTH (AMT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // bench copy of the block's stores and registers
  logic [AMT_W-1:0] alloc_tbl [MAXP][MAXR];
  logic [AMT_W-1:0] need_tbl  [MAXP][MAXR];
  logic [AMT_W-1:0] avail_cnt [MAXR];
  // which entries have been loaded; a run never touches one that was not
  bit               alloc_set [MAXP][MAXR];
  bit               need_set  [MAXP][MAXR];
  bit               avail_set [MAXR];
  logic [dd_pkg::CFG_W-1:0] proc_cnt = dd_pkg::CFG_COUNT_RESET;
  logic [dd_pkg::CFG_W-1:0] res_cnt  = dd_pkg::CFG_COUNT_RESET;

  report_t pending_reports [$];
  report_t head;

  int  n_errors   = 0;
  int  n_items    = 0;
  int  n_runs     = 0;
  int  n_reports  = 0;
  int  n_settings = 0;
  int  cycle_cnt  = 0;
  bit  idle_on    = 1'b1;   // random idling on both channels
  int  gap_pct    = 30;     // chance of a sender gap before an item

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing report ends up here
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure: random stall bursts, with
  // occasional long stretches of steady ready
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idle_on && $urandom_range(0, 99) < 12) begin
        out_ch.ready = 1'b0;
        hold = $urandom_range(1, 8) - 1;
      end else if (idle_on && $urandom_range(0, 99) < 3) begin
        out_ch.ready = 1'b1;
        hold = $urandom_range(20, 60);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // clamp a count register the way the block reads it
  function automatic int clamp_count(logic [dd_pkg::CFG_W-1:0] v, int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic void queue_report(dd_pkg::kind_t k, int pid, logic dead, logic fin);
    pending_reports.push_back('{k, dd_pkg::IDX_W'(pid), dead, fin});
  endfunction

  // apply one accepted item to the bench stores; a run walks the processes
  // and queues the completed / deadlocked reports and the closing summary
  function automatic void predict_reports(dd_pkg::action_t act,
                                          logic [dd_pkg::IDX_W-1:0] pi,
                                          logic [dd_pkg::IDX_W-1:0] ri,
                                          logic [AMT_W-1:0] amt);
    logic [20:0] work [MAXR];
    bit          finished [MAXP];
    int          np, nr, done_cnt, p, r;
    bit          progress, fits, any_dead;
    case (act)
      dd_pkg::ACT_LOAD_ALLOC: begin
        alloc_tbl[pi][ri] = amt;
        alloc_set[pi][ri] = 1'b1;
      end
      dd_pkg::ACT_LOAD_REQ: begin
        need_tbl[pi][ri] = amt;
        need_set[pi][ri] = 1'b1;
      end
      dd_pkg::ACT_LOAD_AVAIL: begin
        // process_index plays no part here
        avail_cnt[ri] = amt;
        avail_set[ri] = 1'b1;
      end
      default: begin
        n_runs++;
        np = clamp_count(proc_cnt, MAXP);
        nr = clamp_count(res_cnt, MAXR);
        for (r = 0; r < MAXR; r++) work[r] = 21'(avail_cnt[r]);
        for (p = 0; p < MAXP; p++) finished[p] = 1'b0;
        done_cnt = 0;
        progress = 1'b1;
        // passes in index order; work grows at once so later processes of
        // the same pass already see the released counts
        while (done_cnt < np && progress) begin
          progress = 1'b0;
          for (p = 0; p < np; p++) begin
            if (!finished[p]) begin
              fits = 1'b1;
              for (r = 0; r < nr; r++) if (21'(need_tbl[p][r]) > work[r]) fits = 1'b0;
              if (fits) begin
                for (r = 0; r < nr; r++) work[r] += 21'(alloc_tbl[p][r]);
                finished[p] = 1'b1;
                progress = 1'b1;
                done_cnt++;
                queue_report(dd_pkg::KIND_COMPLETED, p, 1'b0, 1'b0);
              end
            end
          end
        end
        any_dead = 1'b0;
        for (p = 0; p < np; p++) begin
          if (!finished[p]) begin
            any_dead = 1'b1;
            queue_report(dd_pkg::KIND_DEADLOCKED, p, 1'b0, 1'b0);
          end
        end
        queue_report(dd_pkg::KIND_SUMMARY, 0, any_dead, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // every report transfer is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected report, expected none, actual kind=%0d pid=%0d dead=%0b last=%0b",
                 $time, out_ch.kind, out_ch.process_id, out_ch.any_deadlock, out_ch.last);
      end else begin
        head = pending_reports.pop_front();
        n_reports++;
        check_field("kind", 8'(head.kind), 8'(out_ch.kind));
        check_field("process_id", 8'(head.pid), 8'(out_ch.process_id));
        check_field("any_deadlock", 8'(head.dead), 8'(out_ch.any_deadlock));
        check_field("last", 8'(head.last), 8'(out_ch.last));
      end
    end
  end

  // one input transfer; drives at the falling edge, maybe after a gap, and
  // leaves valid high so a following item goes back to back
  task automatic send_item(dd_pkg::action_t act, logic [dd_pkg::IDX_W-1:0] pi,
                           logic [dd_pkg::IDX_W-1:0] ri, logic [AMT_W-1:0] amt);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.action         = act;
    in_ch.process_index  = pi;
    in_ch.resource_index = ri;
    in_ch.amount         = amt;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    predict_reports(act, pi, ri, amt);
  endtask

  // a run with junk in the fields it ignores
  task automatic send_run();
    send_item(dd_pkg::ACT_RUN, dd_pkg::IDX_W'($urandom), dd_pkg::IDX_W'($urandom),
              AMT_W'($urandom));
  endtask

  // mostly small counts so fits and deadlocks both happen, some full range
  function automatic logic [AMT_W-1:0] pick_amount();
    if ($urandom_range(0, 99) < 80) return AMT_W'($urandom_range(0, 4));
    return AMT_W'($urandom);
  endfunction

  // drop valid, wait for every report, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [dd_pkg::CFG_IDX_W-1:0] idx, logic [dd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == dd_pkg::CFG_NUM_PROCESSES) proc_cnt = val;
    else if (idx == dd_pkg::CFG_NUM_RESOURCES) res_cnt = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_sizes(int np, int nr);
    settle();
    write_reg(dd_pkg::CFG_NUM_PROCESSES, dd_pkg::CFG_W'(np));
    write_reg(dd_pkg::CFG_NUM_RESOURCES, dd_pkg::CFG_W'(nr));
    n_settings++;
  endtask

  // load every entry the current sizes will read and that is still unset;
  // all available counts go in on the first call
  task automatic fill_unwritten();
    int p, r;
    for (r = 0; r < MAXR; r++)
      if (!avail_set[r])
        send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), dd_pkg::IDX_W'(r),
                  pick_amount());
    for (p = 0; p < clamp_count(proc_cnt, MAXP); p++) begin
      for (r = 0; r < clamp_count(res_cnt, MAXR); r++) begin
        if (!alloc_set[p][r])
          send_item(dd_pkg::ACT_LOAD_ALLOC, dd_pkg::IDX_W'(p), dd_pkg::IDX_W'(r),
                    pick_amount());
        if (!need_set[p][r])
          send_item(dd_pkg::ACT_LOAD_REQ, dd_pkg::IDX_W'(p), dd_pkg::IDX_W'(r),
                    pick_amount());
      end
    end
  endtask

  // mostly inside the active window; the rest lands in rows and columns
  // beyond it, which must be kept for later larger settings
  task automatic send_random_load(int np, int nr);
    dd_pkg::action_t          act;
    logic [dd_pkg::IDX_W-1:0] pi, ri;
    act = dd_pkg::action_t'(dd_pkg::ACT_W'($urandom_range(0, 2)));
    if ($urandom_range(0, 99) < 80) begin
      pi = dd_pkg::IDX_W'($urandom_range(0, np - 1));
      ri = dd_pkg::IDX_W'($urandom_range(0, nr - 1));
    end else begin
      pi = dd_pkg::IDX_W'($urandom);
      ri = dd_pkg::IDX_W'($urandom);
    end
    send_item(act, pi, ri, pick_amount());
  endtask

  // one process, one resource: full-scale counts on the fit boundary
  task automatic test_single_process();
    set_sizes(1, 1);
    fill_unwritten();
    send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), 4'd0, 16'hFFFF);
    send_item(dd_pkg::ACT_LOAD_REQ, 4'd0, 4'd0, 16'hFFFF);
    send_item(dd_pkg::ACT_LOAD_ALLOC, 4'd0, 4'd0, 16'hFFFF);
    send_run();                      // request equals available: completes
    send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), 4'd0, 16'hFFFE);
    send_run();                      // one short: deadlocked
    send_item(dd_pkg::ACT_LOAD_REQ, 4'd0, 4'd0, 16'h0000);
    send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), 4'd0, 16'h0000);
    send_run();                      // zero against zero still fits
  endtask

  // three processes, two resources: finishing takes a second pass, and a
  // process finished early in a pass frees counts for a later one
  task automatic test_pass_order();
    set_sizes(3, 2);
    fill_unwritten();
    send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), 4'd0, 16'd1);
    send_item(dd_pkg::ACT_LOAD_AVAIL, dd_pkg::IDX_W'($urandom), 4'd1, 16'd0);
    for (int p = 0; p < 3; p++) begin
      send_item(dd_pkg::ACT_LOAD_REQ, dd_pkg::IDX_W'(p), 4'd0,
                (p == 0) ? 16'd2 : (p == 2) ? 16'd1 : 16'd0);
      send_item(dd_pkg::ACT_LOAD_REQ, dd_pkg::IDX_W'(p), 4'd1, (p == 1) ? 16'd1 : 16'd0);
      send_item(dd_pkg::ACT_LOAD_ALLOC, dd_pkg::IDX_W'(p), 4'd0, (p == 0) ? 16'd0 : 16'd1);
      send_item(dd_pkg::ACT_LOAD_ALLOC, dd_pkg::IDX_W'(p), 4'd1, (p == 0) ? 16'd1 : 16'd0);
    end
    send_run();                      // order 2, 0, 1
    send_item(dd_pkg::ACT_LOAD_REQ, 4'd1, 4'd1, 16'd5);
    send_run();                      // process 1 left deadlocked
  endtask

  // no processes, spare register indexes, no resources
  task automatic test_zero_counts();
    set_sizes(0, 1);
    send_run();                      // summary only
    settle();
    write_reg(CFG_SPARE_A, 5'd7);
    write_reg(CFG_SPARE_B, 5'd31);
    send_run();                      // spare writes changed nothing
    set_sizes(3, 0);
    send_run();                      // everyone fits with no resources
  endtask

  // largest counts on each register, including values above the store size
  task automatic test_count_extremes();
    int sizes [4][2] = '{'{16, 1}, '{31, 2}, '{1, 16}, '{2, 24}};
    for (int i = 0; i < 4; i++) begin
      set_sizes(sizes[i][0], sizes[i][1]);
      fill_unwritten();
      repeat (2) begin
        repeat ($urandom_range(1, 4))
          send_random_load(clamp_count(proc_cnt, MAXP), clamp_count(res_cnt, MAXR));
        send_run();
      end
    end
  endtask

  // random settings, each with a few load bursts closed by a run; the last
  // stretch runs with no idling on either side
  task automatic test_random_traffic();
    int base, np, nr, sel;
    base = n_items;
    while (n_items - base < RAND_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        np = $urandom_range(1, 5);
        nr = $urandom_range(1, 4);
      end else if (sel < 80) begin
        np = $urandom_range(6, 16);
        nr = $urandom_range(1, 3);
      end else begin
        np = $urandom_range(1, 3);
        nr = $urandom_range(5, 16);
      end
      if ($urandom_range(0, 19) == 0) begin
        if (np >= 6) np = $urandom_range(17, 31);
        else if (nr >= 5) nr = $urandom_range(17, 31);
      end
      if (n_items - base > RAND_TARGET * 4 / 5) idle_on = 1'b0;
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      set_sizes(np, nr);
      fill_unwritten();
      repeat ($urandom_range(3, 7)) begin
        repeat ($urandom_range(0, 6))
          send_random_load(clamp_count(proc_cnt, MAXP), clamp_count(res_cnt, MAXR));
        send_run();
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.action         = dd_pkg::ACT_LOAD_ALLOC;
    in_ch.process_index  = '0;
    in_ch.resource_index = '0;
    in_ch.amount         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_process();
    test_pass_order();
    test_zero_counts();
    test_count_extremes();
    test_random_traffic();
    settle();

    $display("covered %0d input transfers, %0d detection runs, %0d reports checked",
             n_items, n_runs, n_reports);
    $display("over %0d size settings: zero, one, full and oversized counts, spare indexes",
             n_settings);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
